>>> rtl/assert_macros.svh
// Assertion macros shared by the biquad section RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/biq_pkg.sv
// Shared constants, payload types, datapath control and saturation for the biquad section.
package biq_pkg;

    localparam int SAMPLE_WIDTH  = 16;
    localparam int COEF_WIDTH    = 24;
    localparam int DELAY_WIDTH   = 48;
    localparam int COEF_FRAC     = COEF_WIDTH - 4;
    localparam int PROD_WIDTH    = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int ACC_WIDTH     = DELAY_WIDTH + 2;
    localparam int RND_WIDTH     = DELAY_WIDTH + 1;
    localparam int CFG_IDX_WIDTH = 3;

    // Output clamp: floor(0.9999 * 2^(SAMPLE_WIDTH-1)) and -1.0
    localparam logic signed [SAMPLE_WIDTH-1:0] Y_HI =
        SAMPLE_WIDTH'((64'd9999 << (SAMPLE_WIDTH - 1)) / 64'd10000);
    localparam logic signed [SAMPLE_WIDTH-1:0] Y_LO = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    localparam logic signed [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(64'd1 << COEF_FRAC);

    // Coefficient register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_B0 = CFG_IDX_WIDTH'(0);
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_B1 = CFG_IDX_WIDTH'(1);
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_B2 = CFG_IDX_WIDTH'(2);
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_A1 = CFG_IDX_WIDTH'(3);
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_A2 = CFG_IDX_WIDTH'(4);

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample_in;
        logic                           frame_end_in;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample_out;
        logic                           frame_end_out;
    } t_out_item;

    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] b0;
        logic signed [COEF_WIDTH-1:0] b1;
        logic signed [COEF_WIDTH-1:0] b2;
        logic signed [COEF_WIDTH-1:0] a1;
        logic signed [COEF_WIDTH-1:0] a2;
    } t_coefs;

    typedef enum logic [2:0] {
        MUL_B0X,
        MUL_B1X,
        MUL_B2X,
        MUL_A1Y,
        MUL_A2Y
    } t_mul_sel;

    typedef enum logic {
        ADD_A_PROD,
        ADD_A_T
    } t_add_a_sel;

    typedef enum logic [1:0] {
        ADD_B_ZERO,
        ADD_B_D1,
        ADD_B_D2,
        ADD_B_PROD
    } t_add_b_sel;

    typedef struct packed {
        logic       x_we;
        t_mul_sel   mul_sel;
        logic       p_we;
        t_add_a_sel a_sel;
        t_add_b_sel b_sel;
        logic       sub;
        logic       t_we;
        logic       d1_we;
        logic       d2_we;
        logic       y_we;
    } t_dp_ctl;

    // Clamp a wide sum into the signed range of a delay register
    function automatic logic signed [DELAY_WIDTH-1:0] sat_dly(
        input logic signed [ACC_WIDTH-1:0] v
    );
        logic signed [DELAY_WIDTH-1:0] r;
        if (v[ACC_WIDTH-1:DELAY_WIDTH-1] == {(ACC_WIDTH-DELAY_WIDTH+1){1'b0}} ||
            v[ACC_WIDTH-1:DELAY_WIDTH-1] == {(ACC_WIDTH-DELAY_WIDTH+1){1'b1}}) begin
            r = v[DELAY_WIDTH-1:0];
        end else if (v[ACC_WIDTH-1]) begin
            r = {1'b1, {(DELAY_WIDTH-1){1'b0}}};
        end else begin
            r = {1'b0, {(DELAY_WIDTH-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

>>> rtl/biq_datapath.sv
// Shared multiplier, saturating adder, output rounding and the two delay registers.
module biq_datapath (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  biq_pkg::t_dp_ctl                       i_ctl,
    input  biq_pkg::t_coefs                        i_coefs,
    input  logic signed [biq_pkg::SAMPLE_WIDTH-1:0] i_sample,
    output logic signed [biq_pkg::SAMPLE_WIDTH-1:0] o_y
);
    import biq_pkg::*;

    localparam logic signed [RND_WIDTH-1:0] HALF = RND_WIDTH'(64'd1 << (COEF_FRAC - 1));

    logic signed [SAMPLE_WIDTH-1:0] r_x;
    logic signed [SAMPLE_WIDTH-1:0] r_y;
    logic signed [PROD_WIDTH-1:0]   r_p;
    logic signed [DELAY_WIDTH-1:0]  r_t;
    logic signed [DELAY_WIDTH-1:0]  r_d1;
    logic signed [DELAY_WIDTH-1:0]  r_d2;

    logic signed [COEF_WIDTH-1:0]   w_mcoef;
    logic signed [SAMPLE_WIDTH-1:0] w_msamp;
    logic signed [PROD_WIDTH-1:0]   w_prod;
    logic signed [DELAY_WIDTH-1:0]  w_psat;
    logic signed [DELAY_WIDTH-1:0]  w_opa;
    logic signed [DELAY_WIDTH-1:0]  w_opb;
    logic signed [ACC_WIDTH-1:0]    w_sum;
    logic signed [DELAY_WIDTH-1:0]  w_add;
    logic signed [RND_WIDTH-1:0]    w_rnd;
    logic signed [RND_WIDTH-1:0]    w_shr;
    logic signed [SAMPLE_WIDTH-1:0] n_y;

    // Multiplier operand select
    always_comb begin
        case (i_ctl.mul_sel)
            MUL_B0X: begin w_mcoef = i_coefs.b0; w_msamp = r_x; end
            MUL_B1X: begin w_mcoef = i_coefs.b1; w_msamp = r_x; end
            MUL_B2X: begin w_mcoef = i_coefs.b2; w_msamp = r_x; end
            MUL_A1Y: begin w_mcoef = i_coefs.a1; w_msamp = r_y; end
            MUL_A2Y: begin w_mcoef = i_coefs.a2; w_msamp = r_y; end
            default: begin w_mcoef = i_coefs.b0; w_msamp = r_x; end
        endcase
    end

    assign w_prod = PROD_WIDTH'(w_mcoef) * PROD_WIDTH'(w_msamp);
    assign w_psat = sat_dly(ACC_WIDTH'(r_p));

    // Adder operand select
    always_comb begin
        case (i_ctl.a_sel)
            ADD_A_PROD: w_opa = w_psat;
            ADD_A_T:    w_opa = r_t;
            default:    w_opa = w_psat;
        endcase
        case (i_ctl.b_sel)
            ADD_B_ZERO: w_opb = '0;
            ADD_B_D1:   w_opb = r_d1;
            ADD_B_D2:   w_opb = r_d2;
            ADD_B_PROD: w_opb = w_psat;
            default:    w_opb = '0;
        endcase
    end

    assign w_sum = i_ctl.sub ? (ACC_WIDTH'(w_opa) - ACC_WIDTH'(w_opb))
                             : (ACC_WIDTH'(w_opa) + ACC_WIDTH'(w_opb));
    assign w_add = sat_dly(w_sum);

    // Round half up, floor shift, then clamp
    assign w_rnd = RND_WIDTH'(r_t) + HALF;
    assign w_shr = w_rnd >>> COEF_FRAC;

    always_comb begin
        if (w_shr > RND_WIDTH'(Y_HI)) begin
            n_y = Y_HI;
        end else if (w_shr < RND_WIDTH'(Y_LO)) begin
            n_y = Y_LO;
        end else begin
            n_y = w_shr[SAMPLE_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.x_we) r_x <= i_sample;
        if (i_ctl.y_we) r_y <= n_y;
        if (i_ctl.p_we) r_p <= w_prod;
        if (i_ctl.t_we) r_t <= w_add;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1 <= '0;
            r_d2 <= '0;
        end else begin
            if (i_ctl.d1_we) r_d1 <= w_add;
            if (i_ctl.d2_we) r_d2 <= w_add;
        end
    end

    assign o_y = r_y;

endmodule

>>> rtl/biq_ctrl.sv
// Step sequencer that drives the shared datapath through one sample.
module biq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_free,
    output biq_pkg::t_dp_ctl o_ctl,
    output logic             o_busy,
    output logic             o_done
);
    import biq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MB0,
        S_ACC,
        S_RND,
        S_MA1,
        S_N1,
        S_MA2,
        S_N2
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_ctl         = '0;
        o_ctl.mul_sel = MUL_B0X;
        o_ctl.a_sel   = ADD_A_PROD;
        o_ctl.b_sel   = ADD_B_ZERO;
        n_state       = r_state;
        o_done        = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.x_we = 1'b1;
                    n_state    = S_MB0;
                end
            end
            S_MB0: begin
                o_ctl.p_we = 1'b1;
                n_state    = S_ACC;
            end
            S_ACC: begin
                // b0*x + delay_one, next product b1*x
                o_ctl.b_sel   = ADD_B_D1;
                o_ctl.t_we    = 1'b1;
                o_ctl.mul_sel = MUL_B1X;
                o_ctl.p_we    = 1'b1;
                n_state       = S_RND;
            end
            S_RND: begin
                o_ctl.y_we  = 1'b1;
                o_ctl.b_sel = ADD_B_D2;
                o_ctl.t_we  = 1'b1;
                n_state     = S_MA1;
            end
            S_MA1: begin
                o_ctl.mul_sel = MUL_A1Y;
                o_ctl.p_we    = 1'b1;
                n_state       = S_N1;
            end
            S_N1: begin
                o_ctl.a_sel   = ADD_A_T;
                o_ctl.b_sel   = ADD_B_PROD;
                o_ctl.sub     = 1'b1;
                o_ctl.d1_we   = 1'b1;
                o_ctl.mul_sel = MUL_B2X;
                o_ctl.p_we    = 1'b1;
                n_state       = S_MA2;
            end
            S_MA2: begin
                o_ctl.t_we    = 1'b1;
                o_ctl.mul_sel = MUL_A2Y;
                o_ctl.p_we    = 1'b1;
                n_state       = S_N2;
            end
            S_N2: begin
                // hold until the output register can take the sample
                if (i_out_free) begin
                    o_ctl.a_sel = ADD_A_T;
                    o_ctl.b_sel = ADD_B_PROD;
                    o_ctl.sub   = 1'b1;
                    o_ctl.d2_we = 1'b1;
                    o_done      = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

>>> rtl/biquad_iir_filter_section_top.sv
// Top level of the biquad IIR section: coefficient registers, sequencer, datapath, output stage.
`include "assert_macros.svh"

// One second-order IIR section in transposed direct form II. Each accepted
// Q1.15 sample is filtered with the five Q4.20 coefficients and one Q1.15
// sample comes out, rounded half up and clamped to -1.0 .. 0.9999 (32764);
// the clamped output feeds the two 48-bit saturating delay registers. A
// sample passes the accept step in idle and seven steps through one shared
// 24x16 multiplier and one 48-bit saturating adder, which every product and
// delay sum of the section passes through in turn. The result is presented
// from the output register after the last step, and the next sample is
// taken only once the section is idle again. o_in_stall stays high while a
// sample is in work. The result waits in an output register, so a stalled
// output adds cycles only when the next result is ready before the previous
// one is taken. The frame-end flag rides along untouched. Coefficients are
// written through the config port (index 0..4: b0, b1, b2, a1, a2; other
// indexes are dropped) and must only change while the section is idle.
// After reset b0 is 1.0 and all others zero.
module biquad_iir_filter_section_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // sample input
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  biq_pkg::t_in_item                     i_in_data,
    // sample output
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output biq_pkg::t_out_item                    o_out_data,
    // coefficient writes
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [biq_pkg::CFG_IDX_WIDTH-1:0]     i_cfg_index,
    input  logic signed [biq_pkg::COEF_WIDTH-1:0] i_cfg_data
);
    import biq_pkg::*;

    t_coefs                         r_coefs;
    logic                           r_frame;
    logic                           r_out_valid;
    t_out_item                      r_out_data;

    t_dp_ctl                        w_ctl;
    logic                           w_busy;
    logic                           w_done;
    logic                           w_out_free;
    logic signed [SAMPLE_WIDTH-1:0] w_y;

    // Coefficient registers: always ready, each write is registered
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.b0 <= COEF_ONE;
            r_coefs.b1 <= '0;
            r_coefs.b2 <= '0;
            r_coefs.a1 <= '0;
            r_coefs.a2 <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_B0:  r_coefs.b0 <= i_cfg_data;
                CFG_B1:  r_coefs.b1 <= i_cfg_data;
                CFG_B2:  r_coefs.b2 <= i_cfg_data;
                CFG_A1:  r_coefs.a1 <= i_cfg_data;
                CFG_A2:  r_coefs.a2 <= i_cfg_data;
                default: ;  // drop writes to unused indexes
            endcase
        end
    end

    // The output slot is free when empty or being drained this cycle
    assign w_out_free = !r_out_valid || !i_out_stall;

    biq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (w_out_free),
        .o_ctl      (w_ctl),
        .o_busy     (w_busy),
        .o_done     (w_done)
    );

    biq_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_coefs  (r_coefs),
        .i_sample (i_in_data.sample_in),
        .o_y      (w_y)
    );

    assign o_in_stall = w_busy;

    // Capture the frame-end flag with the sample
    always_ff @(posedge i_clk) begin
        if (w_ctl.x_we) r_frame <= i_in_data.frame_end_in;
    end

    // Output register: load on completion, clear once transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out_data.sample_out    <= w_y;
            r_out_data.frame_end_out <= r_frame;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `ASSERT_NEXT(a_start, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "no start")
    `ASSERT_IMPL(a_done_while_busy, i_clk, i_rst_n, w_done, w_busy, "done while idle")
    `ASSERT_IMPL(a_no_overwrite, i_clk, i_rst_n, w_done, w_out_free, "result overwritten")
    `ASSERT_NEXT(a_done_shows, i_clk, i_rst_n, w_done, o_out_valid, "result not presented")
    `ASSERT_IMPL(a_clamp, i_clk, i_rst_n, o_out_valid, o_out_data.sample_out <= Y_HI, "above clamp")

endmodule
